/* rtl/sis_pkg.sv */
package sis_pkg;

	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_FIND   = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;
	localparam logic [1:0] REQ_CLEAR  = 2'd3;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] value;
		logic [5:0]         index;
	} req_item_t;

	typedef struct packed {
		logic       accepted;
		logic       found;
		logic [5:0] position;
		logic [6:0] count;
	} rsp_item_t;

	typedef struct packed {
		logic               compare;
		logic               insert;
		logic               remove;
		logic signed [31:0] value;
		logic [5:0]         index;
		logic [6:0]         count;
	} cell_ctrl_t;

endpackage

/* rtl/sorted_integer_set_unit.sv */
// Sorted set of distinct signed 32-bit integers held in a row of register cells.
// Each item goes through the accept, parallel compare and shift-and-answer steps; the result is
// registered in the last step, and no new item is taken until the previous one has answered.
// A stalled result holds the answer step until the output register frees up.
// Reset empties the set and sets the capacity limit to 64; entry contents stay undefined.
module sorted_integer_set_unit
	import sis_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  req_item_t  req,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_item_t  rsp,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [6:0] cfg_data
);

	localparam int         CAP_MAX   = (DEPTH < 127) ? DEPTH : 127;
	localparam logic [6:0] CAP_MAX_C = 7'(CAP_MAX);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	logic [1:0]  state_q;
	req_item_t   req_q;
	logic [6:0]  count_q;
	logic [6:0]  cap_q;
	rsp_item_t   rsp_q;
	logic        rsp_valid_q;

	logic signed [31:0] entry_w [DEPTH];
	logic               lt_w    [DEPTH];
	logic               eq_w    [DEPTH];
	cell_ctrl_t         ctrl;

	logic       advance;
	logic       any_eq;
	logic [5:0] match_pos;
	logic [6:0] eff_cap;
	logic       do_add;
	logic       do_remove;
	rsp_item_t  rsp_next;
	logic [6:0] count_next;

	assign eff_cap   = (cap_q < CAP_MAX_C) ? cap_q : CAP_MAX_C;
	assign advance   = (state_q == ST_EXEC) && (!rsp_valid_q || !rsp_stall);
	assign req_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	always_comb begin
		any_eq    = 1'b0;
		match_pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			any_eq    = any_eq | eq_w[i];
			match_pos = match_pos | (eq_w[i] ? 6'(i) : 6'd0);
		end
	end

	assign do_add    = (req_q.req_type == REQ_ADD) && (count_q < eff_cap) && !any_eq;
	assign do_remove = (req_q.req_type == REQ_REMOVE) && ({1'b0, req_q.index} < count_q);

	always_comb begin
		rsp_next   = '0;
		count_next = count_q;
		unique case (req_q.req_type)
			REQ_ADD: begin
				rsp_next.accepted = do_add;
				if (do_add) begin
					count_next = count_q + 7'd1;
				end
			end
			REQ_FIND: begin
				rsp_next.found    = any_eq;
				rsp_next.position = match_pos;
			end
			REQ_REMOVE: begin
				rsp_next.accepted = do_remove;
				if (do_remove) begin
					count_next = count_q - 7'd1;
				end
			end
			REQ_CLEAR: begin
				rsp_next.accepted = 1'b1;
				count_next        = '0;
			end
			default: begin
				rsp_next = '0;
			end
		endcase
		rsp_next.count = count_next;
	end

	assign ctrl.compare = (state_q == ST_CMP);
	assign ctrl.insert  = advance && do_add;
	assign ctrl.remove  = advance && do_remove;
	assign ctrl.value   = req_q.value;
	assign ctrl.index   = req_q.index;
	assign ctrl.count   = count_q;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic               left_lt;
		logic signed [31:0] left_entry;
		logic signed [31:0] right_entry;

		if (g == 0) begin : g_first
			assign left_lt    = 1'b1;
			assign left_entry = '0;
		end else begin : g_mid
			assign left_lt    = lt_w[g-1];
			assign left_entry = entry_w[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign right_entry = '0;
		end else begin : g_inner
			assign right_entry = entry_w[g+1];
		end

		sis_cell #(
			.CELL_INDEX(g)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.left_lt    (left_lt),
			.left_entry (left_entry),
			.right_entry(right_entry),
			.entry      (entry_w[g]),
			.lt         (lt_w[g]),
			.eq         (eq_w[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cap_q       <= 7'd64;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (advance) begin
						count_q <= count_next;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			req_q <= req;
		end
		if (advance) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* rtl/sis_cell.sv */
module sis_cell
	import sis_pkg::*;
#(
	parameter int CELL_INDEX = 0
) (
	input  logic               clk,
	input  cell_ctrl_t         ctrl,
	input  logic               left_lt,
	input  logic signed [31:0] left_entry,
	input  logic signed [31:0] right_entry,
	output logic signed [31:0] entry,
	output logic               lt,
	output logic               eq
);

	localparam bit         IN_COUNT_RANGE = CELL_INDEX < 128;
	localparam bit         ABOVE_INDEX    = CELL_INDEX >= 64;
	localparam logic [6:0] IDX_COUNT      = 7'(CELL_INDEX);
	localparam logic [5:0] IDX_POS        = 6'(CELL_INDEX);

	logic signed [31:0] entry_q;
	logic               lt_q;
	logic               eq_q;
	logic               occupied;
	logic               at_or_above;

	assign occupied    = IN_COUNT_RANGE && (IDX_COUNT < ctrl.count);
	assign at_or_above = ABOVE_INDEX || (IDX_POS >= ctrl.index);

	always_ff @(posedge clk) begin
		if (ctrl.compare) begin
			lt_q <= occupied && (entry_q < ctrl.value);
			eq_q <= occupied && (entry_q == ctrl.value);
		end
		if (ctrl.insert && !lt_q) begin
			entry_q <= left_lt ? ctrl.value : left_entry;
		end else if (ctrl.remove && at_or_above) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;
	assign lt    = lt_q;
	assign eq    = eq_q;

endmodule
